// ===== rtl/core/glmd_pkg.sv =====
// Shared types and constants for the grid local minimum detector.
package glmd_pkg;

    localparam int HEIGHT_BITS    = 4;
    localparam int COORD_BITS     = 7;
    localparam int RISK_BITS      = 18;
    localparam int CFG_DATA_BITS  = 8;
    localparam int REG_RESET      = 100;
    localparam int DEF_MAX_WIDTH  = 128;
    localparam int DEF_MAX_HEIGHT = 128;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    typedef enum logic [0:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic                   op;
        logic [HEIGHT_BITS-1:0] height_in;
    } t_in_item;

    typedef struct packed {
        logic [COORD_BITS-1:0]  col;
        logic [COORD_BITS-1:0]  row;
        logic [HEIGHT_BITS-1:0] height_out;
        logic                   is_low;
        logic [RISK_BITS-1:0]   risk_total;
        logic                   frame_done;
    } t_out_item;

    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

endpackage

// ===== rtl/core/glmd_cell.sv =====
// One storage cell of a line buffer chain: holds a single pixel height.
module glmd_cell (
    input  logic                            i_clk,
    input  glmd_pkg::t_cell_ctl             i_ctl,
    input  logic [glmd_pkg::HEIGHT_BITS-1:0] i_prev,
    input  logic [glmd_pkg::HEIGHT_BITS-1:0] i_new,
    output logic [glmd_pkg::HEIGHT_BITS-1:0] o_q
);
    import glmd_pkg::*;

    logic [HEIGHT_BITS-1:0] r_q;
    logic [HEIGHT_BITS-1:0] n_q;

    // The cell at the insertion point takes the fresh pixel, the others its neighbor's.
    always_comb begin
        n_q = r_q;
        if (i_ctl.shift) begin
            n_q = i_ctl.load ? i_new : i_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;

endmodule

// ===== rtl/core/glmd_line.sv =====
// Line buffer built as a chain of cells with a run-time selectable delay.
module glmd_line #(
    parameter int DEPTH = glmd_pkg::DEF_MAX_WIDTH
) (
    input  logic                             i_clk,
    input  logic                             i_shift,
    input  logic [$clog2(DEPTH+1)-1:0]       i_delay,
    input  logic [glmd_pkg::HEIGHT_BITS-1:0] i_din,
    output logic [glmd_pkg::HEIGHT_BITS-1:0] o_dout
);
    import glmd_pkg::*;

    localparam int DW = $clog2(DEPTH + 1);

    logic [HEIGHT_BITS-1:0] w_q [DEPTH];

    // New pixels enter at cell DEPTH-delay, so the last cell shows the pixel
    // pushed delay items ago.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        t_cell_ctl              w_ctl;
        logic [HEIGHT_BITS-1:0] w_prev;

        assign w_ctl.shift = i_shift;
        assign w_ctl.load  = (i_delay == DW'(DEPTH - i));

        if (i == 0) begin : g_head
            assign w_prev = i_din;
        end else begin : g_body
            assign w_prev = w_q[i-1];
        end

        glmd_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (w_ctl),
            .i_prev (w_prev),
            .i_new  (i_din),
            .o_q    (w_q[i])
        );
    end

    assign o_dout = (i_delay == '0) ? i_din : w_q[DEPTH-1];

endmodule

// ===== rtl/core/grid_local_minimum_detector.sv =====
// Grid local minimum detector: streaming four-neighbor low point finder.
// A verdict is registered and valid in the cycle after the item that releases it is accepted.
// Throughput: one item per cycle while the output drains; both line buffers shift once per item acted on.
// Reset (synchronous, active low) sets width and height to 100 and restarts the frame;
// line buffer contents are not cleared and need no clearing pass.
module grid_local_minimum_detector #(
    parameter int MAX_WIDTH  = glmd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = glmd_pkg::DEF_MAX_HEIGHT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  glmd_pkg::t_cfg_index               i_cfg_index,
    input  logic [glmd_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  glmd_pkg::t_in_item                 i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output glmd_pkg::t_out_item                o_out_data
);
    import glmd_pkg::*;

    // Column counter and the short line's delay share one width.
    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CMPWW = (WW > CFG_DATA_BITS) ? WW : CFG_DATA_BITS;
    localparam int CMPHW = (HW > CFG_DATA_BITS) ? HW : CFG_DATA_BITS;
    localparam int WIDTH_RESET  = (REG_RESET > MAX_WIDTH)  ? MAX_WIDTH  : REG_RESET;
    localparam int HEIGHT_RESET = (REG_RESET > MAX_HEIGHT) ? MAX_HEIGHT : REG_RESET;

    // Control state.
    logic [WW-1:0]        r_width,  n_width;
    logic [HW-1:0]        r_height, n_height;
    logic [AW-1:0]        r_col,    n_col;
    logic [RW-1:0]        r_row,    n_row;
    logic                 r_flushing, n_flushing;
    logic [RISK_BITS-1:0] r_risk,   n_risk;
    logic                 r_out_valid, n_out_valid;

    // Payload state.
    t_out_item              r_out,    n_out;
    logic [HEIGHT_BITS-1:0] r_center, n_center;
    logic [HEIGHT_BITS-1:0] r_left,   n_left;

    logic [HEIGHT_BITS-1:0] w_right;
    logic [HEIGHT_BITS-1:0] w_up;
    logic [WW-1:0]          w_cfg_width;
    logic [HW-1:0]          w_cfg_height;
    logic                   w_cfg_acc;
    logic                   w_in_acc;
    logic                   w_act_sample;
    logic                   w_act_flush;
    logic                   w_shift;
    logic                   w_emit;
    logic                   w_col_last;
    logic                   w_row_last;
    logic                   w_has_left;
    logic                   w_has_right;
    logic                   w_has_up;
    logic                   w_has_down;
    logic                   w_low;
    logic [RISK_BITS:0]     w_risk_wide;
    logic [RISK_BITS-1:0]   w_risk_new;
    logic [RW-1:0]          w_judged_row;

    // The window around the judged pixel is taken from two cell chains.
    // The short line delays the stream by width-1 items and gives the right
    // neighbor; two single registers behind it hold the center and the left
    // neighbor. The long line delays the center by one more row and gives the
    // pixel above. The pixel below is the item now arriving. Flush ticks push
    // filler data, so the window stays aligned while the last row drains.
    glmd_line #(
        .DEPTH (MAX_WIDTH - 1)
    ) u_line_near (
        .i_clk   (i_clk),
        .i_shift (w_shift),
        .i_delay (AW'(r_width - WW'(1))),
        .i_din   (i_in_data.height_in),
        .o_dout  (w_right)
    );

    glmd_line #(
        .DEPTH (MAX_WIDTH)
    ) u_line_far (
        .i_clk   (i_clk),
        .i_shift (w_shift),
        .i_delay (r_width),
        .i_din   (r_center),
        .o_dout  (w_up)
    );

    // Configuration values are clamped into the supported range when written.
    always_comb begin
        if (i_cfg_data == '0) begin
            w_cfg_width = WW'(1);
        end else if (CMPWW'(i_cfg_data) > CMPWW'(MAX_WIDTH)) begin
            w_cfg_width = WW'(MAX_WIDTH);
        end else begin
            w_cfg_width = WW'(i_cfg_data);
        end
        if (i_cfg_data == '0) begin
            w_cfg_height = HW'(1);
        end else if (CMPHW'(i_cfg_data) > CMPHW'(MAX_HEIGHT)) begin
            w_cfg_height = HW'(MAX_HEIGHT);
        end else begin
            w_cfg_height = HW'(i_cfg_data);
        end
    end

    assign o_cfg_ready = 1'b1;
    assign w_cfg_acc   = i_cfg_valid & o_cfg_ready;

    // The output register frees itself in the same cycle it is drained.
    assign o_in_ready = ~r_out_valid | i_out_ready;
    assign w_in_acc   = i_in_valid & o_in_ready;

    // A sample during the flush phase and a flush outside it are dropped.
    assign w_act_sample = w_in_acc & (i_in_data.op == OP_SAMPLE) & ~r_flushing;
    assign w_act_flush  = w_in_acc & (i_in_data.op == OP_FLUSH) & r_flushing;
    assign w_shift      = w_act_sample | w_act_flush;

    // Samples of the first row release nothing; every flush tick releases one verdict.
    assign w_emit = w_act_flush | (w_act_sample & (r_row != '0));

    assign w_col_last = (r_col == AW'(r_width - WW'(1)));
    assign w_row_last = (r_row == RW'(r_height - HW'(1)));

    // While sampling, the judged pixel sits one row above the arriving one.
    // While flushing, it sits on the last row itself and has no pixel below.
    assign w_judged_row = r_flushing ? r_row : (r_row - RW'(1));
    assign w_has_left   = (r_col != '0);
    assign w_has_right  = ~w_col_last;
    assign w_has_up     = r_flushing ? (r_row != '0) : (r_row > RW'(1));
    assign w_has_down   = ~r_flushing;

    assign w_low = (~w_has_left  | (r_left  > r_center))
                 & (~w_has_right | (w_right > r_center))
                 & (~w_has_up    | (w_up    > r_center))
                 & (~w_has_down  | (i_in_data.height_in > r_center));

    // Running risk sum saturates at its all-ones value.
    assign w_risk_wide = {1'b0, r_risk} + (RISK_BITS+1)'(r_center) + (RISK_BITS+1)'(1);
    always_comb begin
        w_risk_new = r_risk;
        if (w_low) begin
            w_risk_new = w_risk_wide[RISK_BITS] ? '1 : w_risk_wide[RISK_BITS-1:0];
        end
    end

    always_comb begin
        n_width     = r_width;
        n_height    = r_height;
        n_col       = r_col;
        n_row       = r_row;
        n_flushing  = r_flushing;
        n_risk      = r_risk;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_center    = r_center;
        n_left      = r_left;

        if (w_shift) begin
            n_center = w_right;
            n_left   = r_center;
        end

        if (w_emit) begin
            n_risk               = w_risk_new;
            n_out_valid          = 1'b1;
            n_out.col            = COORD_BITS'(r_col);
            n_out.row            = COORD_BITS'(w_judged_row);
            n_out.height_out     = r_center;
            n_out.is_low         = w_low;
            n_out.risk_total     = w_risk_new;
            n_out.frame_done     = w_act_flush & w_col_last;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (w_act_sample) begin
            if (w_col_last) begin
                n_col = '0;
                if (w_row_last) begin
                    n_flushing = 1'b1;
                end else begin
                    n_row = r_row + RW'(1);
                end
            end else begin
                n_col = r_col + AW'(1);
            end
        end

        // The flush of the last column closes the frame.
        if (w_act_flush) begin
            if (w_col_last) begin
                n_col      = '0;
                n_row      = '0;
                n_flushing = 1'b0;
                n_risk     = '0;
            end else begin
                n_col = r_col + AW'(1);
            end
        end

        // A register write takes effect at once and restarts the frame.
        if (w_cfg_acc) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH: begin
                    n_width = w_cfg_width;
                end
                CFG_IMAGE_HEIGHT: begin
                    n_height = w_cfg_height;
                end
                default: begin
                    n_width = r_width;
                end
            endcase
            n_col      = '0;
            n_row      = '0;
            n_flushing = 1'b0;
            n_risk     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= WW'(WIDTH_RESET);
            r_height    <= HW'(HEIGHT_RESET);
            r_col       <= '0;
            r_row       <= '0;
            r_flushing  <= 1'b0;
            r_risk      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_width     <= n_width;
            r_height    <= n_height;
            r_col       <= n_col;
            r_row       <= n_row;
            r_flushing  <= n_flushing;
            r_risk      <= n_risk;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out    <= n_out;
        r_center <= n_center;
        r_left   <= n_left;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== bench/grid_local_minimum_detector_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the grid local minimum detector: random and directed frames.
module grid_local_minimum_detector_tb;
    import glmd_pkg::*;

    // Two rows of line storage for the predictor: entry (row & 1, col).
    localparam int LINE_SLOTS   = 2 * DEF_MAX_WIDTH;
    localparam int SLOT_BITS    = $clog2(LINE_SLOTS);
    localparam int RISK_CEILING = (1 << RISK_BITS) - 1;
    // Far beyond the slowest correct run, which has under a thousand items.
    localparam int CYCLE_LIMIT  = 100000;
    // Long enough for the block to fill and drop its input ready.
    localparam int HOLD_CYCLES  = 150;
    // The block answers in the cycle after the item that releases a verdict; the rest is margin.
    localparam int DRAIN_CYCLES = 4;

    typedef logic [HEIGHT_BITS-1:0] t_height;
    typedef logic [SLOT_BITS-1:0]   t_slot;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    t_cfg_index               cfg_index = CFG_IMAGE_WIDTH;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;
    logic                     in_valid  = 1'b0;
    logic                     in_ready;
    t_in_item                 in_data   = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    t_out_item                out_data;

    // Shadow copy of the detector state, updated as items and register writes are accepted.
    t_height                  line_mem [LINE_SLOTS];
    logic [CFG_DATA_BITS-1:0] width_reg;
    logic [CFG_DATA_BITS-1:0] height_reg;
    int unsigned              feed_col;
    int unsigned              feed_row;
    int unsigned              flush_col;
    int unsigned              risk_sum;
    bit                       draining;

    // Verdicts the block still owes us, oldest first, and items not yet offered.
    t_out_item                pending_verdicts[$];
    t_in_item                 pixel_feed[$];

    int unsigned              items_queued       = 0;
    int unsigned              items_taken        = 0;
    int unsigned              verdict_count      = 0;
    int unsigned              mismatch_count     = 0;
    int unsigned              cycle_count        = 0;
    int unsigned              sender_idle_pct    = 0;
    int unsigned              receiver_stall_pct = 0;
    bit                       pressure_armed     = 1'b0;
    logic                     rx_hold            = 1'b0;

    grid_local_minimum_detector i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // A register value of zero means one; anything past the maximum means the maximum.
    function automatic int unsigned clamp_size(logic [CFG_DATA_BITS-1:0] value,
                                               int unsigned limit);
        if (value == '0) begin
            return 1;
        end
        if (32'(value) > limit) begin
            return limit;
        end
        return 32'(value);
    endfunction

    function automatic t_slot line_slot(int unsigned row, int unsigned col);
        return t_slot'((row % 2) * DEF_MAX_WIDTH + col);
    endfunction

    function automatic void restart_frame();
        feed_col  = 0;
        feed_row  = 0;
        flush_col = 0;
        risk_sum  = 0;
        draining  = 1'b0;
    endfunction

    function automatic void reset_predictor();
        width_reg  = CFG_DATA_BITS'(REG_RESET);
        height_reg = CFG_DATA_BITS'(REG_RESET);
        foreach (line_mem[i]) begin
            line_mem[i] = '0;
        end
        pending_verdicts.delete();
        restart_frame();
    endfunction

    // Judges the stored pixel (x, y). The pixel below is only known when the item
    // that releases the verdict is a sample of the next row.
    function automatic void judge_pixel(int unsigned x, int unsigned y, bit has_below,
                                        t_height below, bit last);
        int unsigned w;
        t_height     here;
        bit          low;
        t_out_item   verdict;
        w    = clamp_size(width_reg, DEF_MAX_WIDTH);
        here = line_mem[line_slot(y, x)];
        low  = 1'b1;
        // Neighbors off the edge of the frame do not take part; ties spoil a low point.
        if (x > 0 && line_mem[line_slot(y, x - 1)] <= here) begin
            low = 1'b0;
        end
        if (y > 0 && line_mem[line_slot(y - 1, x)] <= here) begin
            low = 1'b0;
        end
        if (x + 1 < w && line_mem[line_slot(y, x + 1)] <= here) begin
            low = 1'b0;
        end
        if (has_below && below <= here) begin
            low = 1'b0;
        end
        if (low) begin
            risk_sum = risk_sum + 32'(here) + 1;
            if (risk_sum > RISK_CEILING) begin
                risk_sum = RISK_CEILING;
            end
        end
        verdict.col        = x[COORD_BITS-1:0];
        verdict.row        = y[COORD_BITS-1:0];
        verdict.height_out = here;
        verdict.is_low     = low;
        verdict.risk_total = risk_sum[RISK_BITS-1:0];
        verdict.frame_done = last;
        pending_verdicts = {pending_verdicts, verdict};
    endfunction

    // Steps the shadow state by one accepted item.
    function automatic void advance_stream(t_in_item item);
        int unsigned w;
        int unsigned h;
        w = clamp_size(width_reg, DEF_MAX_WIDTH);
        h = clamp_size(height_reg, DEF_MAX_HEIGHT);
        if (item.op == OP_SAMPLE) begin
            // Samples that arrive while the last row drains are dropped.
            if (draining) begin
                return;
            end
            if (feed_col >= w) begin
                feed_col = 0;
            end
            if (feed_row > 0) begin
                judge_pixel(feed_col, feed_row - 1, 1'b1, item.height_in, 1'b0);
            end
            line_mem[line_slot(feed_row, feed_col)] = item.height_in;
            if (feed_col + 1 >= w) begin
                feed_col = 0;
                if (feed_row + 1 >= h) begin
                    draining  = 1'b1;
                    flush_col = 0;
                end else begin
                    feed_row++;
                end
            end else begin
                feed_col++;
            end
        end else if (draining) begin
            // A flush outside the draining stage falls through and does nothing.
            if (flush_col >= w) begin
                flush_col = 0;
            end
            if (flush_col + 1 >= w) begin
                judge_pixel(flush_col, feed_row, 1'b0, '0, 1'b1);
                restart_frame();
            end else begin
                judge_pixel(flush_col, feed_row, 1'b0, '0, 1'b0);
                flush_col++;
            end
        end
    endfunction

    // Any register write restarts the frame; the line storage keeps its contents.
    function automatic void apply_register(t_cfg_index index, logic [CFG_DATA_BITS-1:0] value);
        case (index)
            CFG_IMAGE_WIDTH: begin
                width_reg = value;
            end
            CFG_IMAGE_HEIGHT: begin
                height_reg = value;
            end
            default: begin
            end
        endcase
        restart_frame();
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    // Every mismatch prints one line and is counted.
    task automatic report_mismatch(string detail);
        mismatch_count++;
        $display("[%0t] verdict %0d: %s", $time, verdict_count, detail);
    endtask

    task automatic check_verdict(t_out_item got);
        t_out_item want;
        verdict_count++;
        if (pending_verdicts.size() == 0) begin
            report_mismatch($sformatf("unexpected verdict for col %0d row %0d",
                                      got.col, got.row));
            return;
        end
        want = pending_verdicts.pop_front();
        if (got.col !== want.col) begin
            report_mismatch($sformatf("col expected %0d, got %0d", want.col, got.col));
        end
        if (got.row !== want.row) begin
            report_mismatch($sformatf("row expected %0d, got %0d", want.row, got.row));
        end
        if (got.height_out !== want.height_out) begin
            report_mismatch($sformatf("height_out expected %0d, got %0d",
                                      want.height_out, got.height_out));
        end
        if (got.is_low !== want.is_low) begin
            report_mismatch($sformatf("is_low expected %0d, got %0d", want.is_low, got.is_low));
        end
        if (got.risk_total !== want.risk_total) begin
            report_mismatch($sformatf("risk_total expected %0d, got %0d",
                                      want.risk_total, got.risk_total));
        end
        if (got.frame_done !== want.frame_done) begin
            report_mismatch($sformatf("frame_done expected %0d, got %0d",
                                      want.frame_done, got.frame_done));
        end
    endtask

    // ------------------------------------------------------------------
    // Driver, monitor, hold-off and watchdog
    // ------------------------------------------------------------------

    // Input driver. An accepted item steps the predictor at the same edge, so its
    // expectation is queued before the block can possibly answer. The next item is
    // offered at once or after random gaps, and valid only drops when nothing is offered.
    always @(posedge clk) begin
        bit slot_free;
        slot_free = !in_valid;
        if (in_valid && in_ready) begin
            advance_stream(in_data);
            items_taken++;
            slot_free = 1'b1;
        end
        if (rst_n && slot_free) begin
            if (pixel_feed.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                in_data  <= pixel_feed.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Output monitor. Ready is redrawn every cycle, and forced low during the hold-off.
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready) begin
                check_verdict(out_data);
            end
            out_ready <= !rx_hold && ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // One long receiver hold-off while the sender keeps offering, so that the block
    // backs up all the way to its input.
    initial begin
        wait (pressure_armed);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    function automatic void queue_item(logic op, t_height value);
        t_in_item item;
        item.op        = op;
        item.height_in = value;
        pixel_feed = {pixel_feed, item};
        items_queued++;
    endfunction

    // Three flavors of terrain: anything, a narrow band full of ties, and cliffs.
    function automatic t_height pick_height(int unsigned style, t_height base);
        case (style)
            0: begin
                return t_height'($urandom_range(15));
            end
            1: begin
                return base + t_height'($urandom_range(2));
            end
            default: begin
                return $urandom_range(1) ? t_height'(15) : t_height'(0);
            end
        endcase
    endfunction

    // One whole frame: every sample in raster order, then one flush per column.
    // With noise, stray flushes land among the samples and stray samples among
    // the flushes; the block has to ignore both.
    function automatic void queue_frame(int unsigned w, int unsigned h, bit noisy);
        int unsigned style;
        t_height     base;
        style = $urandom_range(2);
        base  = t_height'($urandom_range(15));
        for (int unsigned n = 0; n < w * h; n++) begin
            if (noisy && $urandom_range(19) == 0) begin
                queue_item(OP_FLUSH, t_height'($urandom_range(15)));
            end
            queue_item(OP_SAMPLE, pick_height(style, base));
        end
        for (int unsigned n = 0; n < w; n++) begin
            if (noisy && $urandom_range(19) == 0) begin
                queue_item(OP_SAMPLE, t_height'($urandom_range(15)));
            end
            queue_item(OP_FLUSH, t_height'($urandom_range(15)));
        end
    endfunction

    // Waits until every item is taken and every verdict is in, then a few cycles more
    // in case the last item released nothing and is still inside the block.
    task automatic wait_idle();
        do begin
            @(posedge clk);
        end while (items_taken != items_queued || pending_verdicts.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(t_cfg_index index, logic [CFG_DATA_BITS-1:0] value);
        wait_idle();
        cfg_index <= index;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do begin
            @(posedge clk);
        end while (!cfg_ready);
        apply_register(index, value);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(logic [CFG_DATA_BITS-1:0] width_value,
                             logic [CFG_DATA_BITS-1:0] height_value);
        write_register(CFG_IMAGE_WIDTH, width_value);
        write_register(CFG_IMAGE_HEIGHT, height_value);
    endtask

    initial begin
        int unsigned phase_start;
        int unsigned frame_w;
        int unsigned frame_h;
        int unsigned stray_count;
        bit          aligned;

        reset_predictor();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: a 3x2 frame whose left column holds ties of zero and whose bottom right corner is a valley.
        // A flush before the frame and a sample while it drains must both be ignored.
        configure(8'd3, 8'd2);
        queue_item(OP_FLUSH, 4'd9);
        queue_item(OP_SAMPLE, 4'd0);
        queue_item(OP_SAMPLE, 4'd15);
        queue_item(OP_SAMPLE, 4'd7);
        queue_item(OP_SAMPLE, 4'd0);
        queue_item(OP_SAMPLE, 4'd15);
        queue_item(OP_SAMPLE, 4'd0);
        queue_item(OP_SAMPLE, 4'd5);
        queue_item(OP_FLUSH, 4'd0);
        queue_item(OP_FLUSH, 4'd15);
        queue_item(OP_FLUSH, 4'd0);
        // The frame is over, so this flush finds nothing to drain.
        queue_item(OP_FLUSH, 4'd3);

        // Zero in both registers means a single pixel, which has no neighbors at all.
        configure(8'd0, 8'd0);
        queue_item(OP_SAMPLE, 4'd9);
        queue_item(OP_FLUSH, 4'd0);

        // A one pixel wide column: only the pixels above and below count.
        write_register(CFG_IMAGE_HEIGHT, 8'd3);
        queue_item(OP_SAMPLE, 4'd4);
        queue_item(OP_SAMPLE, 4'd2);
        queue_item(OP_SAMPLE, 4'd8);
        queue_item(OP_FLUSH, 4'd0);

        // Random frames in four idling phases. Phase zero also carries the widest
        // frame and the receiver hold-off; phase two carries the tallest frame.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1: begin
                    sender_idle_pct    = 50;
                    receiver_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 50;
                end
                default: begin
                    sender_idle_pct    = 28;
                    receiver_stall_pct = 28;
                end
            endcase
            if (phase == 0) begin
                configure(8'd128, 8'd1);
                queue_frame(DEF_MAX_WIDTH, 1, 1'b0);
                pressure_armed = 1'b1;
            end else if (phase == 2) begin
                // 255 is past the maximum and is taken as the full height.
                configure(8'd1, 8'd255);
                queue_frame(1, DEF_MAX_HEIGHT, 1'b1);
            end
            aligned     = 1'b0;
            phase_start = items_queued;
            while (items_queued - phase_start < 20) begin
                if (aligned && $urandom_range(3) == 0) begin
                    // Same size again, straight after the previous frame ended.
                    queue_frame(frame_w, frame_h, 1'b1);
                end else if ($urandom_range(5) == 0) begin
                    // Any register values and a loose run of items, usually cut off
                    // mid-frame by the next register write.
                    configure(CFG_DATA_BITS'($urandom_range(255)),
                              CFG_DATA_BITS'($urandom_range(255)));
                    stray_count = $urandom_range(1, 40);
                    for (int unsigned n = 0; n < stray_count; n++) begin
                        queue_item(logic'($urandom_range(1)), t_height'($urandom_range(15)));
                    end
                    aligned = 1'b0;
                end else begin
                    frame_w = $urandom_range(1, 9);
                    frame_h = $urandom_range(1, 5);
                    configure(CFG_DATA_BITS'(frame_w), CFG_DATA_BITS'(frame_h));
                    queue_frame(frame_w, frame_h, 1'b1);
                    aligned = 1'b1;
                end
            end
        end

        wait_idle();
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
